// ===== src/rcfmq_pkg.sv =====
// Shared types and constants for the record cache first-match queue.
package rcfmq_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int TYPE_W   = 8;
   localparam int ES_W     = 64;
   localparam int LEN_W    = 16;
   localparam int HANDLE_W = 16;
   localparam int EPOCH_W  = 16;
   localparam int HELD_W   = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [1:0] FUNC_APPEND = 2'd0;
   localparam logic [1:0] FUNC_TAKE   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_APP_TYPE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HS_TYPE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_UNK_TYPE = 2'd2;

   localparam logic [TYPE_W-1:0] APP_TYPE_RST = 8'd23;
   localparam logic [TYPE_W-1:0] HS_TYPE_RST  = 8'd22;
   localparam logic [TYPE_W-1:0] UNK_TYPE_RST = 8'd255;

   typedef struct packed {
      logic [TYPE_W-1:0]   rec_type;
      logic [ES_W-1:0]     epoch_seq;
      logic [LEN_W-1:0]    body_len;
      logic [HANDLE_W-1:0] body_handle;
   } entry_type;

   typedef struct packed {
      logic                eval;
      logic                append;
      logic                shift;
      logic [EPOCH_W-1:0]  want_epoch;
      logic [TYPE_W-1:0]   want_type;
      logic [TYPE_W-1:0]   app_code;
      logic [TYPE_W-1:0]   hs_code;
      logic [TYPE_W-1:0]   unk_code;
   } cell_ctl_type;

endpackage

// ===== src/rcfmq_cell.sv =====
// One queue slot: holds an entry, flags a match, and passes the first-match chain on.
module rcfmq_cell #(
   parameter int MAX_ENTRIES = rcfmq_pkg::MAX_ENTRIES_DEF,
   parameter int IDX         = 0,
   parameter int CNT_W       = $clog2(MAX_ENTRIES + 1)
) (
   input  logic                     clock,
   input  rcfmq_pkg::cell_ctl_type  ctl,
   input  logic [CNT_W-1:0]         fill,
   input  rcfmq_pkg::entry_type     new_entry,
   input  rcfmq_pkg::entry_type     nbr_entry,
   input  logic                     prior_in,
   input  rcfmq_pkg::entry_type     sel_in,
   output rcfmq_pkg::entry_type     entry,
   output logic                     prior_out,
   output rcfmq_pkg::entry_type     sel_out
);

   rcfmq_pkg::entry_type entry_ff, entry_in;
   logic                 match_ff, match_in;
   logic                 occupied;
   logic                 rule_ok;
   logic                 hit;

   assign occupied = CNT_W'(IDX) < fill;

   assign rule_ok = (ctl.want_type == ctl.unk_code) ||
                    (entry_ff.rec_type != ctl.app_code) ||
                    (ctl.want_type != ctl.hs_code);

   assign match_in = ctl.eval ? (occupied && rule_ok &&
                     (entry_ff.epoch_seq[rcfmq_pkg::ES_W-1 -: rcfmq_pkg::EPOCH_W] ==
                      ctl.want_epoch)) : match_ff;

   // first hit in the row wins; everything behind it moves up one slot
   assign hit       = match_ff && !prior_in;
   assign prior_out = prior_in || match_ff;
   assign sel_out   = hit ? entry_ff : sel_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.append && (fill == CNT_W'(IDX))) begin
         entry_in = new_entry;
      end else if (ctl.shift && prior_out) begin
         entry_in = nbr_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

   assign entry = entry_ff;

endmodule

// ===== src/record_cache_first_match_queue.sv =====
// Top level of the record cache first-match queue: control, config and a row of slot cells.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | func, record fields, want_epoch, want_type
//  rsp     | out       | rsp_valid/rsp_ready  | status, taken entry fields, entries_held
//  csr     | in        | csr_wr_en            | csr_index, csr_wr_data
//
// Each beat first compares all slots in parallel, then resolves the
// first hit along the cell row, compacts and updates the fill count.
// The next beat is taken in the compact cycle when the result register is free.
// Reset clears the fill count and control state and loads the default type codes; slots need no clearing.
// A stalled result holds the block in its compact cycle until rsp_ready.
module record_cache_first_match_queue #(
   parameter int MAX_ENTRIES = rcfmq_pkg::MAX_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_func,
   input  logic [rcfmq_pkg::TYPE_W-1:0]        req_rec_type,
   input  logic [rcfmq_pkg::ES_W-1:0]          req_rec_epoch_seq,
   input  logic [rcfmq_pkg::LEN_W-1:0]         req_rec_body_len,
   input  logic [rcfmq_pkg::HANDLE_W-1:0]      req_rec_body_handle,
   input  logic [rcfmq_pkg::EPOCH_W-1:0]       req_want_epoch,
   input  logic [rcfmq_pkg::TYPE_W-1:0]        req_want_type,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [rcfmq_pkg::TYPE_W-1:0]        rsp_out_type,
   output logic [rcfmq_pkg::ES_W-1:0]          rsp_out_epoch_seq,
   output logic [rcfmq_pkg::LEN_W-1:0]         rsp_out_body_len,
   output logic [rcfmq_pkg::HANDLE_W-1:0]      rsp_out_body_handle,
   output logic [rcfmq_pkg::HELD_W-1:0]        rsp_entries_held,
   input  logic                                csr_wr_en,
   input  logic [rcfmq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rcfmq_pkg::TYPE_W-1:0]        csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = (CNT_W > rcfmq_pkg::HELD_W) ? CNT_W : rcfmq_pkg::HELD_W;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_MATCH   = 2'd1;
   localparam logic [1:0] S_COMPACT = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic [rcfmq_pkg::TYPE_W-1:0]    app_ff, app_in, hs_ff, hs_in, unk_ff, unk_in;

   logic [1:0]                      func_ff;
   rcfmq_pkg::entry_type            rec_ff;
   logic [rcfmq_pkg::EPOCH_W-1:0]   want_epoch_ff;
   logic [rcfmq_pkg::TYPE_W-1:0]    want_type_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [1:0]                      status_ff, status_in;
   rcfmq_pkg::entry_type            out_ff;
   logic [rcfmq_pkg::HELD_W-1:0]    held_ff;

   logic                            req_take;
   logic                            out_free;
   logic                            commit;
   logic                            found;
   logic                            is_full;
   logic [EXT_W-1:0]                fill_ext;
   rcfmq_pkg::cell_ctl_type         ctl;

   rcfmq_pkg::entry_type            ent   [MAX_ENTRIES];
   logic                            prior [MAX_ENTRIES+1];
   rcfmq_pkg::entry_type            sel   [MAX_ENTRIES+1];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == S_COMPACT) && out_free;
   assign req_ready = (state_ff == S_IDLE) || commit;
   assign req_take  = req_valid && req_ready;
   assign is_full   = fill_ff == CNT_W'(MAX_ENTRIES);
   assign found     = prior[MAX_ENTRIES];

   assign ctl.eval       = state_ff == S_MATCH;
   assign ctl.append     = commit && (func_ff == rcfmq_pkg::FUNC_APPEND);
   assign ctl.shift      = commit && (func_ff == rcfmq_pkg::FUNC_TAKE) && found;
   assign ctl.want_epoch = want_epoch_ff;
   assign ctl.want_type  = want_type_ff;
   assign ctl.app_code   = app_ff;
   assign ctl.hs_code    = hs_ff;
   assign ctl.unk_code   = unk_ff;

   assign prior[0] = 1'b0;
   assign sel[0]   = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      rcfmq_pkg::entry_type nbr;
      if (i == MAX_ENTRIES - 1) begin : g_last
         assign nbr = ent[i];
      end else begin : g_mid
         assign nbr = ent[i+1];
      end
      rcfmq_cell #(
         .MAX_ENTRIES (MAX_ENTRIES),
         .IDX         (i),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .fill      (fill_ff),
         .new_entry (rec_ff),
         .nbr_entry (nbr),
         .prior_in  (prior[i]),
         .sel_in    (sel[i]),
         .entry     (ent[i]),
         .prior_out (prior[i+1]),
         .sel_out   (sel[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_MATCH;
         end
         S_MATCH: begin
            state_in = S_COMPACT;
         end
         S_COMPACT: begin
            if (commit) state_in = req_take ? S_MATCH : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      fill_in   = fill_ff;
      status_in = rcfmq_pkg::ST_OK;
      unique case (func_ff)
         rcfmq_pkg::FUNC_APPEND: begin
            if (is_full) status_in = rcfmq_pkg::ST_FULL;
            else fill_in = fill_ff + CNT_W'(1);
         end
         rcfmq_pkg::FUNC_TAKE: begin
            if (found) fill_in = fill_ff - CNT_W'(1);
            else status_in = rcfmq_pkg::ST_NOMATCH;
         end
         rcfmq_pkg::FUNC_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   assign fill_ext = EXT_W'(fill_in);

   always_comb begin
      app_in = app_ff;
      hs_in  = hs_ff;
      unk_in = unk_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            rcfmq_pkg::REG_APP_TYPE: app_in = csr_wr_data;
            rcfmq_pkg::REG_HS_TYPE:  hs_in  = csr_wr_data;
            rcfmq_pkg::REG_UNK_TYPE: unk_in = csr_wr_data;
            default:                 app_in = app_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         app_ff       <= rcfmq_pkg::APP_TYPE_RST;
         hs_ff        <= rcfmq_pkg::HS_TYPE_RST;
         unk_ff       <= rcfmq_pkg::UNK_TYPE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         app_ff       <= app_in;
         hs_ff        <= hs_in;
         unk_ff       <= unk_in;
         if (commit) fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff               <= req_func;
         rec_ff.rec_type       <= req_rec_type;
         rec_ff.epoch_seq      <= req_rec_epoch_seq;
         rec_ff.body_len       <= req_rec_body_len;
         rec_ff.body_handle    <= req_rec_body_handle;
         want_epoch_ff         <= req_want_epoch;
         want_type_ff          <= req_want_type;
      end
      if (commit) begin
         status_ff <= status_in;
         // sel chain carries zeros when nothing was hit
         out_ff    <= (func_ff == rcfmq_pkg::FUNC_TAKE) ? sel[MAX_ENTRIES] : '0;
         held_ff   <= fill_ext[rcfmq_pkg::HELD_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_out_type        = out_ff.rec_type;
   assign rsp_out_epoch_seq   = out_ff.epoch_seq;
   assign rsp_out_body_len    = out_ff.body_len;
   assign rsp_out_body_handle = out_ff.body_handle;
   assign rsp_entries_held    = held_ff;

endmodule
